>>> src/buddy_allocator_assert.svh
// Assertion macros shared by the buddy allocator checkers.
// Needs a signal named clock and a signal named reset in the including scope.
`ifndef BUDDY_ALLOCATOR_ASSERT_SVH
`define BUDDY_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define BA_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("buddy allocator check failed");

// Next-cycle implication, disabled while reset is high.
`define BA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("buddy allocator check failed");

`endif

>>> src/ba_pkg.sv
// Types, constants and helper functions of the buddy allocator.
// No dependencies; used by the top level, both checkers and the testbench.
package ba_pkg;

   localparam int MAX_LEVEL   = 10;
   localparam int NUM_LEVELS  = MAX_LEVEL + 1;
   localparam int LEVEL_W     = 4;
   localparam int OFF_W       = 10;
   localparam int SIZE_W      = 11;
   localparam int POOL_UNITS  = 1 << MAX_LEVEL;
   localparam int WORD_BITS   = 32;
   localparam int BIT_IDX_W   = 5;
   localparam int WORD_IDX_W  = OFF_W - BIT_IDX_W;
   localparam int FM_ADDR_W   = LEVEL_W + WORD_IDX_W;
   localparam int FM_DEPTH    = 1 << FM_ADDR_W;

   localparam logic [2:0] STATUS_OK      = 3'd0;
   localparam logic [2:0] STATUS_ZERO    = 3'd1;
   localparam logic [2:0] STATUS_BIG     = 3'd2;
   localparam logic [2:0] STATUS_OOM     = 3'd3;
   localparam logic [2:0] STATUS_BADFREE = 3'd4;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef struct packed {
      logic              req_type;
      logic [SIZE_W-1:0] req_size;
      logic [OFF_W-1:0]  free_offset;
   } req_beat_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [OFF_W-1:0]   grant_offset;
      logic [LEVEL_W-1:0] grant_level;
   } rsp_beat_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ALOOK,
      ST_APICK,
      ST_SPLIT_RD,
      ST_SET_RD,
      ST_SET_WR,
      ST_MARK,
      ST_FCHK,
      ST_MRD,
      ST_MCHK,
      ST_RESP
   } ba_state_type;

   // Index of the lowest set bit of a word; zero when the word is empty.
   function automatic logic [BIT_IDX_W-1:0] lowest_set(input logic [WORD_BITS-1:0] w);
      logic [BIT_IDX_W-1:0] r;
      r = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (w[i]) begin
            r = BIT_IDX_W'(i);
         end
      end
      return r;
   endfunction

   // Level of the smallest power of two that holds size units (size nonzero).
   function automatic logic [LEVEL_W-1:0] size_level(input logic [SIZE_W-1:0] size);
      logic [SIZE_W-1:0]  v;
      logic [LEVEL_W-1:0] r;
      v = size - SIZE_W'(1);
      r = '0;
      for (int i = 0; i < SIZE_W; i++) begin
         if (v[i]) begin
            r = LEVEL_W'(i + 1);
         end
      end
      return r;
   endfunction

endpackage

>>> src/buddy_allocator.sv
// Buddy allocator top level: sequencer, free-node bitmap memory and grant memory.
// Depends on ba_pkg.
//
// Channel  Direction  Handshake               Payload
// req      in         req_valid / req_stall   req_data  (req_beat_type)
// rsp      out        rsp_valid / rsp_stall   rsp_data  (rsp_beat_type)
//
// One beat is handled at a time; req_stall is high from acceptance until the
// result beat has been taken. An allocate searches up the levels for a free node,
// takes it, splits it down one level per read and write, and marks the grant; a
// free checks its grant entry, merges upward while the buddy is free, and frees
// the merged node. Zero and oversize requests go straight to the result, a bad
// free after its grant check. Each split or merge reads a free-node word and
// writes it back. The result beat holds until it is taken, and the block then
// returns to idle, where it takes the next beat.
// After reset all 1024 grant memory entries are swept clear, with req_stall high.
// A stalled result simply holds in its register.
module buddy_allocator (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ba_pkg::req_beat_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ba_pkg::rsp_beat_type rsp_data
);
   import ba_pkg::*;

   // The free-node map is kept as one bitmap per level, in 32-bit words of a
   // memory addressed by {level, word}. A summary bit per word in flip-flops
   // tells whether the word holds any free node; a word whose summary bit is
   // clear reads as empty, so the memory needs no clearing of its own.
   logic [WORD_BITS-1:0]  fm_mem [FM_DEPTH];
   logic [WORD_BITS-1:0]  fm_rdata_ff;
   logic [FM_ADDR_W-1:0]  fm_raddr;
   logic                  fm_we;
   logic [FM_ADDR_W-1:0]  fm_waddr;
   logic [WORD_BITS-1:0]  fm_wdata;

   // Grant memory: one entry per unit offset, {allocated mark, level}.
   logic [LEVEL_W:0]      am_mem [POOL_UNITS];
   logic [LEVEL_W:0]      am_rdata_ff;
   logic [OFF_W-1:0]      am_raddr;
   logic                  am_we;
   logic [OFF_W-1:0]      am_waddr;
   logic [LEVEL_W:0]      am_wdata;

   logic [NUM_LEVELS-1:0][WORD_BITS-1:0] summary_ff, summary_in;

   ba_state_type          state_ff, state_in;
   logic                  op_ff, op_in;
   logic [LEVEL_W-1:0]    want_ff, want_in;
   logic [LEVEL_W-1:0]    lv_ff, lv_in;
   logic [OFF_W-1:0]      off_ff, off_in;
   logic [OFF_W-1:0]      idx_ff, idx_in;
   logic [OFF_W-1:0]      clr_ff, clr_in;
   rsp_beat_type          rsp_ff, rsp_in;

   logic [WORD_BITS-1:0]  fm_word;
   logic [WORD_BITS-1:0]  bit_mask;
   logic [BIT_IDX_W-1:0]  pick_bit;
   logic [LEVEL_W-1:0]    next_lv;
   logic [OFF_W-1:0]      shifted_off;

   always_ff @(posedge clock) begin
      if (fm_we) begin
         fm_mem[fm_waddr] <= fm_wdata;
      end
      fm_rdata_ff <= fm_mem[fm_raddr];
   end

   always_ff @(posedge clock) begin
      if (am_we) begin
         am_mem[am_waddr] <= am_wdata;
      end
      am_rdata_ff <= am_mem[am_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_ff     <= '0;
         // Only the root word of the top level starts with a free node.
         summary_ff <= (NUM_LEVELS * WORD_BITS)'(1) << (MAX_LEVEL * WORD_BITS);
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         summary_ff <= summary_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      want_ff <= want_in;
      lv_ff   <= lv_in;
      off_ff  <= off_in;
      idx_ff  <= idx_in;
      rsp_ff  <= rsp_in;
   end

   // The word read last cycle, taken as empty when its summary bit is clear.
   assign fm_word  = summary_ff[lv_ff][idx_ff[OFF_W-1:BIT_IDX_W]] ? fm_rdata_ff : '0;
   assign bit_mask = WORD_BITS'(1) << idx_ff[BIT_IDX_W-1:0];
   assign pick_bit = lowest_set(fm_rdata_ff);
   assign next_lv  = lv_ff - LEVEL_W'(1);
   assign am_raddr = (state_ff == ST_IDLE) ? req_data.free_offset : off_ff;

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      want_in     = want_ff;
      lv_in       = lv_ff;
      off_in      = off_ff;
      idx_in      = idx_ff;
      clr_in      = clr_ff;
      rsp_in      = rsp_ff;
      summary_in  = summary_ff;
      fm_raddr    = {lv_ff, idx_ff[OFF_W-1:BIT_IDX_W]};
      fm_we       = 1'b0;
      fm_waddr    = {lv_ff, idx_ff[OFF_W-1:BIT_IDX_W]};
      fm_wdata    = fm_word | bit_mask;
      am_we       = 1'b0;
      am_waddr    = off_ff;
      am_wdata    = {1'b1, want_ff};
      shifted_off = off_ff >> lv_ff;
      req_stall   = (state_ff != ST_IDLE);
      rsp_valid   = (state_ff == ST_RESP);

      case (state_ff)
         ST_CLEAR: begin
            // Sweep the grant memory and seed the root word of the top level.
            am_we    = 1'b1;
            am_waddr = clr_ff;
            am_wdata = '0;
            fm_we    = 1'b1;
            fm_waddr = {LEVEL_W'(MAX_LEVEL), WORD_IDX_W'(0)};
            fm_wdata = WORD_BITS'(1);
            clr_in   = clr_ff + OFF_W'(1);
            if (clr_ff == OFF_W'(POOL_UNITS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               op_in   = req_data.req_type;
               off_in  = req_data.free_offset;
               rsp_in  = '0;
               want_in = size_level(req_data.req_size);
               lv_in   = size_level(req_data.req_size);
               if (req_data.req_type == OP_FREE) begin
                  state_in = ST_FCHK;
               end else if (req_data.req_size == '0) begin
                  rsp_in.status = STATUS_ZERO;
                  state_in      = ST_RESP;
               end else if (req_data.req_size > SIZE_W'(POOL_UNITS)) begin
                  rsp_in.status = STATUS_BIG;
                  state_in      = ST_RESP;
               end else begin
                  state_in = ST_ALOOK;
               end
            end
         end
         ST_ALOOK: begin
            // Walk up the levels until one has a free node.
            if (summary_ff[lv_ff] != '0) begin
               idx_in   = {lowest_set(summary_ff[lv_ff]), BIT_IDX_W'(0)};
               fm_raddr = {lv_ff, lowest_set(summary_ff[lv_ff])};
               state_in = ST_APICK;
            end else if (lv_ff == LEVEL_W'(MAX_LEVEL)) begin
               rsp_in.status = STATUS_OOM;
               state_in      = ST_RESP;
            end else begin
               lv_in = lv_ff + LEVEL_W'(1);
            end
         end
         ST_APICK: begin
            // Take the lowest free node of the word and mark it used.
            fm_we    = 1'b1;
            fm_wdata = fm_rdata_ff & ~(WORD_BITS'(1) << pick_bit);
            if ((fm_rdata_ff & ~(WORD_BITS'(1) << pick_bit)) == '0) begin
               summary_in[lv_ff][idx_ff[OFF_W-1:BIT_IDX_W]] = 1'b0;
            end
            off_in = {idx_ff[OFF_W-1:BIT_IDX_W], pick_bit} << lv_ff;
            if (lv_ff == want_ff) begin
               state_in = ST_MARK;
            end else begin
               state_in = ST_SPLIT_RD;
            end
         end
         ST_SPLIT_RD: begin
            // The right half one level down becomes free.
            lv_in    = next_lv;
            idx_in   = (off_ff >> next_lv) + OFF_W'(1);
            fm_raddr = {next_lv, idx_in[OFF_W-1:BIT_IDX_W]};
            state_in = ST_SET_WR;
         end
         ST_SET_RD: begin
            idx_in   = shifted_off;
            fm_raddr = {lv_ff, shifted_off[OFF_W-1:BIT_IDX_W]};
            state_in = ST_SET_WR;
         end
         ST_SET_WR: begin
            fm_we = 1'b1;
            summary_in[lv_ff][idx_ff[OFF_W-1:BIT_IDX_W]] = 1'b1;
            if (op_ff == OP_FREE) begin
               rsp_in.status = STATUS_OK;
               state_in      = ST_RESP;
            end else if (lv_ff == want_ff) begin
               state_in = ST_MARK;
            end else begin
               state_in = ST_SPLIT_RD;
            end
         end
         ST_MARK: begin
            am_we                = 1'b1;
            rsp_in.status        = STATUS_OK;
            rsp_in.grant_offset  = off_ff;
            rsp_in.grant_level   = want_ff;
            state_in             = ST_RESP;
         end
         ST_FCHK: begin
            // The grant entry for the offset was read at acceptance.
            if (!am_rdata_ff[LEVEL_W]) begin
               rsp_in.status = STATUS_BADFREE;
               state_in      = ST_RESP;
            end else begin
               am_we    = 1'b1;
               am_wdata = {1'b0, am_rdata_ff[LEVEL_W-1:0]};
               lv_in    = am_rdata_ff[LEVEL_W-1:0];
               state_in = ST_MRD;
            end
         end
         ST_MRD: begin
            if (lv_ff == LEVEL_W'(MAX_LEVEL)) begin
               state_in = ST_SET_RD;
            end else begin
               idx_in   = shifted_off ^ OFF_W'(1);
               fm_raddr = {lv_ff, idx_in[OFF_W-1:BIT_IDX_W]};
               state_in = ST_MCHK;
            end
         end
         ST_MCHK: begin
            // Merge while the buddy is free.
            if ((fm_word & bit_mask) != '0) begin
               fm_we    = 1'b1;
               fm_wdata = fm_word & ~bit_mask;
               if ((fm_word & ~bit_mask) == '0) begin
                  summary_in[lv_ff][idx_ff[OFF_W-1:BIT_IDX_W]] = 1'b0;
               end
               off_in   = off_ff & ~(OFF_W'(1) << lv_ff);
               lv_in    = lv_ff + LEVEL_W'(1);
               state_in = ST_MRD;
            end else begin
               state_in = ST_SET_RD;
            end
         end
         ST_RESP: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_data = rsp_ff;

endmodule

>>> src/ba_checker.sv
// Port-level checker for the buddy allocator, bound to the top level.
// Depends on ba_pkg and buddy_allocator_assert.svh.
`include "buddy_allocator_assert.svh"

module ba_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input ba_pkg::rsp_beat_type rsp_data
);
   import ba_pkg::*;

   logic rsp_err;
   logic grant_fits;

   assign rsp_err    = (rsp_data.status != STATUS_OK);
   assign grant_fits = (rsp_data.grant_level <= LEVEL_W'(MAX_LEVEL)) &&
                       (((rsp_data.grant_offset >> rsp_data.grant_level)
                         << rsp_data.grant_level) == rsp_data.grant_offset);

   // A stalled result beat holds.
   `BA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // No request beat is taken while a result waits.
   `BA_ASSERT_IMPL(a_one_at_a_time, req_valid && !req_stall, !rsp_valid)

   // Error results carry zero offset and level.
   `BA_ASSERT_IMPL(a_err_zero, rsp_valid && rsp_err, rsp_data[OFF_W+LEVEL_W-1:0] == '0)

   // A granted block is aligned to its own size and within the pool levels.
   `BA_ASSERT_IMPL(a_grant_aligned, rsp_valid && !rsp_err, grant_fits)

endmodule

bind buddy_allocator ba_checker u_ba_checker (.*);

>>> test/buddy_allocator_checker.sv
// Checker for the buddy allocator: watches both channels, predicts each result beat
// and compares it field by field. Depends on ba_pkg.
`timescale 1ns / 1ps
module buddy_allocator_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  ba_pkg::req_beat_type req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  ba_pkg::rsp_beat_type rsp_data,
   output int                   fail_count,
   output int                   pending_count
);
   import ba_pkg::*;

   // Free bit per tree node, heap order with the root at index 1.
   logic                   node_free [1:2*POOL_UNITS-1];
   logic                   block_live [0:POOL_UNITS-1];
   logic [LEVEL_W-1:0]     block_level [0:POOL_UNITS-1];
   rsp_beat_type           grant_q [$];

   function automatic int node_index(input int off, input int lv);
      return (1 << (MAX_LEVEL - lv)) + (off >> lv);
   endfunction

   // Applies one request to the mirrored pool and returns its result beat.
   function automatic rsp_beat_type pool_apply(input req_beat_type b);
      rsp_beat_type r;
      int want, lv, off, base;
      bit found;
      r = '{status: STATUS_OK, grant_offset: '0, grant_level: '0};
      want = 0;
      off = 0;
      found = 0;
      if (b.req_type == OP_ALLOC) begin
         if (b.req_size == 0) begin
            r.status = STATUS_ZERO;
         end else if (b.req_size > POOL_UNITS) begin
            r.status = STATUS_BIG;
         end else begin
            while ((1 << want) < b.req_size) want++;
            for (lv = want; lv <= MAX_LEVEL && !found; lv++) begin
               base = 1 << (MAX_LEVEL - lv);
               for (int i = 0; i < base && !found; i++) begin
                  if (node_free[base + i]) begin
                     found = 1;
                     off = i << lv;
                     node_free[base + i] = 0;
                  end
               end
               if (found) break;
            end
            if (!found) begin
               r.status = STATUS_OOM;
            end else begin
               // Split down, leaving every right half free.
               while (lv > want) begin
                  lv--;
                  node_free[node_index(off + (1 << lv), lv)] = 1;
               end
               block_live[off] = 1;
               block_level[off] = LEVEL_W'(want);
               r.grant_offset = OFF_W'(off);
               r.grant_level = LEVEL_W'(want);
            end
         end
      end else begin
         off = b.free_offset;
         if (!block_live[off]) begin
            r.status = STATUS_BADFREE;
         end else begin
            lv = block_level[off];
            block_live[off] = 0;
            while (lv < MAX_LEVEL && node_free[node_index(off ^ (1 << lv), lv)]) begin
               node_free[node_index(off ^ (1 << lv), lv)] = 0;
               off = off & ~(1 << lv);
               lv++;
            end
            node_free[node_index(off, lv)] = 1;
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int exp_v);
      $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, exp_v, $realtime);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending_count = 0;
      for (int n = 1; n < 2*POOL_UNITS; n++) node_free[n] = (n == 1);
      for (int u = 0; u < POOL_UNITS; u++) begin
         block_live[u] = 0;
         block_level[u] = '0;
      end
   end

   always @(posedge clock) begin
      rsp_beat_type exp_beat;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (grant_q.size() == 0) begin
               report_mismatch("result beat with nothing expected", rsp_data.status, -1);
            end else begin
               exp_beat = grant_q.pop_front();
               if (rsp_data.status != exp_beat.status)
                  report_mismatch("status", rsp_data.status, exp_beat.status);
               if (rsp_data.grant_offset != exp_beat.grant_offset)
                  report_mismatch("grant_offset", rsp_data.grant_offset,
                                  exp_beat.grant_offset);
               if (rsp_data.grant_level != exp_beat.grant_level)
                  report_mismatch("grant_level", rsp_data.grant_level,
                                  exp_beat.grant_level);
            end
         end
         if (req_valid && !req_stall) grant_q.push_back(pool_apply(req_data));
         pending_count = grant_q.size();
      end
   end

endmodule

>>> test/buddy_allocator_tb.sv
// Testbench top for the buddy allocator: clock, reset, request stimulus and verdict.
// Depends on ba_pkg, buddy_allocator and buddy_allocator_checker.
`timescale 1ns / 1ps
module buddy_allocator_tb;
   import ba_pkg::*;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_beat_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_beat_type rsp_data;
   int           fail_count;
   int           pending_count;

   // Idling percentages for the current phase, and a long receiver hold-off.
   int           send_idle_pct;
   int           recv_stall_pct;
   logic         hold_off;
   int           cycle_count = 0;

   // Offsets the block has granted and that have not yet been freed. Frees
   // mostly draw from here so that merges actually happen; the rest are
   // random offsets that exercise the bad-free path.
   int           live_offsets [$];
   logic         sent_ops [$];
   int           alloc_count, free_count;

   buddy_allocator u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   buddy_allocator_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // Safety net: the slowest correct run is far below this.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 2000000) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Receiver side: random stall per cycle, forced high during a hold-off.
   always @(negedge clock) begin
      rsp_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
   end

   // Track grants so that later frees can target live blocks. Results come
   // back in request order, one per request beat.
   always @(posedge clock) begin
      logic op;
      if (!reset && rsp_valid && !rsp_stall && sent_ops.size() > 0) begin
         op = sent_ops.pop_front();
         if (op == OP_ALLOC && rsp_data.status == STATUS_OK)
            live_offsets.push_back(rsp_data.grant_offset);
      end
   end

   // Offers one request beat and returns at the edge where it is taken.
   task automatic send_beat(input logic op, input int size, input int off);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{req_type: op, req_size: SIZE_W'(size), free_offset: OFF_W'(off)};
      do @(posedge clock); while (req_stall);
      sent_ops.push_back(op);
      if (op == OP_FREE) begin
         free_count++;
         foreach (live_offsets[k]) begin
            if (live_offsets[k] == off) begin
               live_offsets.delete(k);
               break;
            end
         end
      end else begin
         alloc_count++;
      end
   endtask

   task automatic go_idle();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // Random mix: mostly small allocations, frees of live blocks, and some
   // noise (zero, oversize, random or repeated free offsets).
   task automatic random_traffic(input int beats);
      int pick, size, off;
      for (int n = 0; n < beats; n++) begin
         pick = $urandom_range(99);
         if (pick < 50 - (live_offsets.size() > 30 ? 25 : 0)) begin
            case ($urandom_range(9))
               0:       size = $urandom_range(2047);
               1:       size = $urandom_range(1024, 129);
               2:       size = 0;
               default: size = $urandom_range(16, 1);
            endcase
            send_beat(OP_ALLOC, size, $urandom_range(1023));
         end else if (pick < 90 && live_offsets.size() > 0) begin
            off = live_offsets[$urandom_range(live_offsets.size() - 1)];
            send_beat(OP_FREE, $urandom_range(2047), off);
         end else begin
            send_beat(OP_FREE, $urandom_range(2047), $urandom_range(1023));
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      hold_off = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      alloc_count = 0;
      free_count = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: each status code, the size extremes, splits down to
      // the smallest unit, a full merge back to the root, and double frees.
      send_beat(OP_ALLOC, 1, 0);
      send_beat(OP_ALLOC, 2, 0);
      send_beat(OP_ALLOC, 3, 0);
      send_beat(OP_ALLOC, 512, 0);
      send_beat(OP_ALLOC, 1024, 0);
      send_beat(OP_FREE, 0, 0);
      send_beat(OP_FREE, 0, 0);
      send_beat(OP_FREE, 0, 1023);
      send_beat(OP_FREE, 0, 2);
      send_beat(OP_FREE, 0, 4);
      send_beat(OP_FREE, 0, 512);
      send_beat(OP_ALLOC, 1024, 0);
      send_beat(OP_ALLOC, 1, 0);
      send_beat(OP_FREE, 2047, 0);
      send_beat(OP_ALLOC, 0, 1023);
      send_beat(OP_ALLOC, 1025, 0);
      send_beat(OP_ALLOC, 2047, 0);
      send_beat(OP_ALLOC, 1023, 0);
      send_beat(OP_ALLOC, 5, 0);
      send_beat(OP_FREE, 0, 8);
      send_beat(OP_FREE, 0, 0);

      // Phase with no idling on either side.
      random_traffic(180);

      // Sender mostly idle.
      send_idle_pct = 84;
      random_traffic(180);

      // The sender pauses here until every expected result has come back.
      go_idle();
      wait (pending_count == 0);

      // Receiver mostly stalling.
      send_idle_pct = 0;
      recv_stall_pct = 84;
      random_traffic(180);

      // Both sides idling now and then.
      send_idle_pct = 24;
      recv_stall_pct = 24;
      random_traffic(180);

      // Receiver holds off for a long stretch while the sender keeps
      // offering beats, so the block fills and stalls its input.
      send_idle_pct = 0;
      recv_stall_pct = 0;
      fork
         begin
            @(negedge clock);
            hold_off <= 1'b1;
            repeat (300) @(negedge clock);
            hold_off <= 1'b0;
         end
      join_none
      random_traffic(200);
      go_idle();

      wait (pending_count == 0);
      repeat (40) @(posedge clock);

      $display("Sent %0d allocate and %0d free beats over five idling phases,",
               alloc_count, free_count);
      $display("including status extremes, full merges and a long receiver hold-off.");
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+src
src/ba_pkg.sv
src/buddy_allocator.sv
src/ba_checker.sv
test/buddy_allocator_checker.sv
test/buddy_allocator_tb.sv
